// ===== rtl/core/abb_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blitter package
// Request and status codes, controller states, the command and status
// bundles between controller and datapath, and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package abb_pkg;

    // Request kinds carried in the slave-side tuser.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Result status codes carried in the master-side tuser.
    localparam logic [2:0] ST_WRITTEN = 3'd0;
    localparam logic [2:0] ST_SKIP    = 3'd1;
    localparam logic [2:0] ST_CLIPPED = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_SETUP   = 3'd4;
    localparam logic [2:0] ST_STRAY   = 3'd5;

    // Configuration register indexes.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Value the frame store holds after reset: opaque black.
    localparam logic [31:0] CLEAR_PIXEL = 32'hFF00_0000;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_MUL,
        S_WRITE,
        S_OUT
    } t_state;

    // One request as taken from the input channel.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [10:0] dest_x;
        logic signed [10:0] dest_y;
        logic [10:0]        src_width;
        logic [10:0]        src_height;
        logic [31:0]        color;
    } t_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write one cleared entry and step the sweep
        logic capture;   // latch the incoming request
        logic eval;      // clip, address and blit position update
        logic read;      // frame store read
        logic mul;       // channel products
        logic write;     // blend, write back and form the result
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

    // floor(p / 255) for any p up to 255 * 255, by reciprocal and correction.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

endpackage

// ===== rtl/core/abb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blitter controller
// Sequences the clearing sweep after reset and the per-request steps:
// capture, evaluate, read, multiply, write back and hand-over.
// ----------------------------------------------------------------------------
module abb_ctrl import abb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // Wait until the output register is empty or being emptied.
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/abb_dpath.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blitter datapath
// Request register, clipping and addressing, blit position, frame store,
// per-channel blend and the output register of the result channel.
// ----------------------------------------------------------------------------
module abb_dpath import abb_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_req        i_req,
    input  logic [8:0]  i_screen_width,
    input  logic [8:0]  i_screen_height,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam logic [10:0] MW = 11'(MAX_WIDTH);
    localparam logic [10:0] MH = 11'(MAX_HEIGHT);

    // Frame store, fixed pitch of MAX_WIDTH.
    logic [31:0] mem [0:DEPTH-1];

    // Request and per-request results.
    t_req        r_req;
    logic [AW-1:0] r_addr;
    logic [2:0]  r_status;
    logic        r_we;
    logic        r_rd;
    logic        r_done;
    logic [31:0] r_rdata;
    logic [15:0] r_ps [0:2];
    logic [15:0] r_pd [0:2];
    logic [31:0] r_pix;
    logic [AW-1:0] r_clr;

    // Blit state.
    logic signed [10:0] r_org_x, n_org_x;
    logic signed [10:0] r_org_y, n_org_y;
    logic [10:0] r_cols, n_cols;
    logic [10:0] r_rows, n_rows;
    logic [10:0] r_cur_col, n_cur_col;
    logic [10:0] r_cur_row, n_cur_row;
    logic        r_active, n_active;

    // Output register.
    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic [2:0]  r_m_user;
    logic        r_m_last;

    logic [2:0]  n_status;
    logic        n_we;
    logic        n_rd;
    logic        n_done;
    logic [10:0] w_sw;
    logic [10:0] w_sh;
    logic signed [12:0] w_tx;
    logic signed [12:0] w_ty;
    logic        w_hit;
    logic [AW-1:0] w_addr;
    logic [7:0]  w_alpha;
    logic [11:0] w_col_inc;
    logic [11:0] w_row_inc;
    logic [23:0] w_rgb;
    logic [31:0] w_value;
    logic [31:0] n_pix;

    assign w_alpha = r_req.color[31:24];

    // Effective screen size, limited by the store's dimensions.
    assign w_sw = ({2'b00, i_screen_width} < MW) ? {2'b00, i_screen_width} : MW;
    assign w_sh = ({2'b00, i_screen_height} < MH) ? {2'b00, i_screen_height} : MH;

    // Target coordinates: the blit position for source pixels, else the request's.
    always_comb begin
        if (r_req.req_type == REQ_PIXEL) begin
            w_tx = {{2{r_org_x[10]}}, r_org_x} + {2'b00, r_cur_col};
            w_ty = {{2{r_org_y[10]}}, r_org_y} + {2'b00, r_cur_row};
        end else begin
            w_tx = {{2{r_req.dest_x[10]}}, r_req.dest_x};
            w_ty = {{2{r_req.dest_y[10]}}, r_req.dest_y};
        end
    end

    // Clipping and frame store address.
    assign w_hit = !w_tx[12] && !w_ty[12] && (w_tx[11:0] < {1'b0, w_sw})
                   && (w_ty[11:0] < {1'b0, w_sh});
    assign w_addr = AW'(w_ty[YW-1:0]) * AW'(MAX_WIDTH) + AW'(w_tx[XW-1:0]);

    assign w_col_inc = {1'b0, r_cur_col} + 12'd1;
    assign w_row_inc = {1'b0, r_cur_row} + 12'd1;

    // Request decode, status and blit position update.
    always_comb begin
        n_status  = ST_CLIPPED;
        n_we      = 1'b0;
        n_rd      = 1'b0;
        n_done    = 1'b0;
        n_org_x   = r_org_x;
        n_org_y   = r_org_y;
        n_cols    = r_cols;
        n_rows    = r_rows;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_active  = r_active;
        unique case (r_req.req_type)
            REQ_PUT: begin
                if (w_hit) begin
                    n_status = (w_alpha == 8'd0) ? ST_SKIP : ST_WRITTEN;
                    n_we     = (w_alpha != 8'd0);
                end
            end
            REQ_BEGIN: begin
                n_status  = ST_SETUP;
                n_org_x   = r_req.dest_x;
                n_org_y   = r_req.dest_y;
                n_cols    = r_req.src_width;
                n_rows    = r_req.src_height;
                n_cur_col = '0;
                n_cur_row = '0;
                n_active  = (r_req.src_width != '0) && (r_req.src_height != '0);
            end
            REQ_PIXEL: begin
                if (!r_active) begin
                    n_status = ST_STRAY;
                end else begin
                    if (w_hit) begin
                        n_status = (w_alpha == 8'd0) ? ST_SKIP : ST_WRITTEN;
                        n_we     = (w_alpha != 8'd0);
                    end
                    // Row-major advance; the last pixel closes the blit.
                    if (w_col_inc >= {1'b0, r_cols}) begin
                        n_cur_col = '0;
                        if (w_row_inc >= {1'b0, r_rows}) begin
                            n_cur_row = '0;
                            n_active  = 1'b0;
                            n_done    = 1'b1;
                        end else begin
                            n_cur_row = w_row_inc[10:0];
                        end
                    end else begin
                        n_cur_col = w_col_inc[10:0];
                    end
                end
            end
            REQ_READ: begin
                if (w_hit) begin
                    n_status = ST_READ;
                    n_rd     = 1'b1;
                end
            end
        endcase
    end

    // Request capture and evaluation results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.eval) begin
            r_addr   <= w_addr;
            r_status <= n_status;
            r_we     <= n_we;
            r_rd     <= n_rd;
            r_done   <= n_done;
        end
    end

    // Blit state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_cols    <= '0;
            r_rows    <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_active  <= 1'b0;
        end else if (i_cmd.eval) begin
            r_org_x   <= n_org_x;
            r_org_y   <= n_org_y;
            r_cols    <= n_cols;
            r_rows    <= n_rows;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_active  <= n_active;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.out_free   = !r_m_valid || i_m_tready;

    // Frame store write port: the clearing sweep or a blend write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr] <= CLEAR_PIXEL;
        end else if (i_cmd.write && r_we) begin
            mem[r_addr] <= w_value;
        end
    end

    // Frame store read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Channel products of source with alpha and of destination with its complement.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_ps[i] <= w_alpha * r_req.color[8*i +: 8];
                r_pd[i] <= (8'd255 - w_alpha) * r_rdata[8*i +: 8];
            end
        end
    end

    // Blend, stored value and result pixel.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rgb[8*i +: 8] = div255(r_ps[i]) + div255(r_pd[i]);
        end
        if (w_alpha == 8'hFF) begin
            w_value = r_req.color;
        end else begin
            w_value = {(r_req.req_type == REQ_PUT) ? 8'hFF : 8'h00, w_rgb};
        end
        if (r_rd) begin
            n_pix = r_rdata;
        end else if (r_we) begin
            n_pix = w_value;
        end else begin
            n_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_pix <= n_pix;
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_data <= r_pix;
            r_m_user <= r_status;
            r_m_last <= r_done;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

// ===== rtl/core/alpha_blend_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blitter unit
// ARGB8888 frame store with put-pixel, blended bitmap blit and readback.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser gives the request kind, tdata
// the coordinates, blit size and colour. Every request gives exactly one
// result transfer on the master stream: tdata the pixel written or read,
// tuser the status, tlast set on the last source pixel of a blit.
// A request is accepted in the idle state and passes through the evaluate,
// read, multiply and write-back states; its result is loaded into the
// output register in the hand-over state, and the next request may be
// accepted in the cycle after the load. The frame store has one write port
// and one registered read port, used by the read and write-back steps.
// After reset the frame store is swept to opaque black, one entry a cycle,
// over all MAX_WIDTH * MAX_HEIGHT entries (65536 at defaults); tready stays
// low during the sweep. The screen size registers on the APB port may be
// written at any time and take effect at once.
// When the receiver stalls, the result waits in the output register and a
// further request is accepted, but its result waits until the first leaves.
// ----------------------------------------------------------------------------
module alpha_blend_blitter_unit import abb_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // dest_x [10:0], dest_y [21:11], src_width [32:22], src_height [43:33],
    // color [75:44], zero fill [79:76]
    input  logic [79:0] i_s_tdata,
    // req_type [1:0]
    input  logic [1:0]  i_s_tuser,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // pixel_value [31:0]
    output logic [31:0] o_m_tdata,
    // status [2:0]
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] r_screen_width;
    logic [8:0] r_screen_height;
    t_req       w_req;
    t_cmd       w_cmd;
    t_sts       w_sts;
    logic       w_cfg_we;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= 9'd256;
            r_screen_height <= 9'd256;
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_SCREEN_WIDTH) begin
                r_screen_width <= pwdata[8:0];
            end else begin
                r_screen_height <= pwdata[8:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? {23'd0, r_screen_width}
                                                   : {23'd0, r_screen_height};

    // Request unpacking.
    assign w_req.req_type   = i_s_tuser;
    assign w_req.dest_x     = i_s_tdata[10:0];
    assign w_req.dest_y     = i_s_tdata[21:11];
    assign w_req.src_width  = i_s_tdata[32:22];
    assign w_req.src_height = i_s_tdata[43:33];
    assign w_req.color      = i_s_tdata[75:44];

    abb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    abb_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req           (w_req),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata),
        .o_m_tuser       (o_m_tuser),
        .o_m_tlast       (o_m_tlast)
    );

endmodule

// ===== rtl/core/abb_checker.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blitter checker
// Port-level checks on the request and result streams, bound to the top.
// ----------------------------------------------------------------------------
module abb_checker import abb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // One request at a time: no transfer in the cycle after an accepted one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= ST_STRAY))
        else $error("undefined status code");

    // Results that neither write nor read carry a zero pixel.
    a_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_SKIP || o_m_tuser == ST_CLIPPED
        || o_m_tuser == ST_SETUP || o_m_tuser == ST_STRAY) |-> o_m_tdata == 32'd0)
        else $error("non-zero pixel on a result without access");

    // The end of a blit is only flagged on a source pixel result.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tuser == ST_WRITTEN
        || o_m_tuser == ST_SKIP || o_m_tuser == ST_CLIPPED))
        else $error("blit end flagged on a result of the wrong kind");

endmodule

bind alpha_blend_blitter_unit abb_checker u_abb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
